// ===== rtl/core/pvq_pkg.sv =====
// pvq_pkg: shared types and constants for the palette vote quantizer.
// Field widths, request codes, palette entry and distance result types.
// No dependencies.
package pvq_pkg;

  localparam int REQ_W       = 2;
  localparam int PIDX_W      = 5;
  localparam int COMP_W      = 8;
  localparam int LIGHT_W     = 15;
  localparam int AB_W        = 16;
  localparam int COLOR_W     = 5;
  localparam int VOTE_OUT_W  = 20;
  localparam int CFG_W       = 6;
  localparam int SQ_W        = 32;
  localparam int DIST_W      = 34;

  localparam logic [CFG_W-1:0] NUM_COLORS_RESET = 6'd30;

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

  typedef struct packed {
    logic        [LIGHT_W-1:0] light;
    logic signed [AB_W-1:0]    green_red;
    logic signed [AB_W-1:0]    blue_yellow;
  } pal_entry_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] sq_sum;
  } dist_t;

endpackage

// ===== rtl/core/pvq_if.sv =====
// pvq_if: request and response channel interfaces (valid/ready plus payload).
// Depends on pvq_pkg for field widths.
interface pvq_req_if;
  import pvq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [PIDX_W-1:0]        palette_index;
  logic [COMP_W-1:0]        component_index;
  logic [LIGHT_W-1:0]       light;
  logic signed [AB_W-1:0]   green_red;
  logic signed [AB_W-1:0]   blue_yellow;

  modport source (output valid, output req_type, output palette_index,
                  output component_index, output light, output green_red,
                  output blue_yellow, input ready);
  modport sink   (input valid, input req_type, input palette_index,
                  input component_index, input light, input green_red,
                  input blue_yellow, output ready);
endinterface

interface pvq_rsp_if;
  import pvq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COLOR_W-1:0]    color_index;
  logic [VOTE_OUT_W-1:0] vote_count;
  logic                  acknowledge;

  modport source (output valid, output color_index, output vote_count,
                  output acknowledge, input ready);
  modport sink   (input valid, input color_index, input vote_count,
                  input acknowledge, output ready);
endinterface

// ===== rtl/core/pvq_palette_mem.sv =====
// pvq_palette_mem: palette storage, one write port, one registered read port.
// Depends on pvq_pkg for the entry type.
module pvq_palette_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                clk,
  input  logic                wen,
  input  logic [AW-1:0]       waddr,
  input  pvq_pkg::pal_entry_t wdata,
  input  logic [AW-1:0]       raddr,
  output pvq_pkg::pal_entry_t rdata
);
  import pvq_pkg::*;

  pal_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pvq_vote_mem.sv =====
// pvq_vote_mem: vote counter storage, one write port, one registered read port.
// No package dependencies.
module pvq_vote_mem #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13,
  parameter int VW    = 20
) (
  input  logic          clk,
  input  logic          wen,
  input  logic [AW-1:0] waddr,
  input  logic [VW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [VW-1:0] rdata
);

  logic [VW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pvq_dist.sv =====
// pvq_dist: two-stage squared Lab distance unit (squares, then sum).
// Depends on pvq_pkg for entry and result types.
module pvq_dist (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pvq_pkg::pal_entry_t pal,
  input  pvq_pkg::pal_entry_t pix,
  output pvq_pkg::dist_t      out
);
  import pvq_pkg::*;

  logic signed [LIGHT_W:0]     dl;
  logic signed [AB_W:0]        da;
  logic signed [AB_W:0]        db;
  logic signed [2*LIGHT_W+1:0] pl;
  logic signed [2*AB_W+1:0]    pa;
  logic signed [2*AB_W+1:0]    pb;
  logic [SQ_W-1:0]             sq_l;
  logic [SQ_W-1:0]             sq_a;
  logic [SQ_W-1:0]             sq_b;
  logic                        v1;

  always_comb begin
    dl = $signed({1'b0, pal.light}) - $signed({1'b0, pix.light});
    da = $signed({pal.green_red[AB_W-1], pal.green_red})
       - $signed({pix.green_red[AB_W-1], pix.green_red});
    db = $signed({pal.blue_yellow[AB_W-1], pal.blue_yellow})
       - $signed({pix.blue_yellow[AB_W-1], pix.blue_yellow});
    pl = dl * dl;
    pa = da * da;
    pb = db * db;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out.valid <= v1;
    end
    sq_l       <= pl[SQ_W-1:0];
    sq_a       <= pa[SQ_W-1:0];
    sq_b       <= pb[SQ_W-1:0];
    out.sq_sum <= DIST_W'(sq_l) + DIST_W'(sq_a) + DIST_W'(sq_b);
  end

endmodule

// ===== rtl/core/palette_vote_quantizer.sv =====
// palette_vote_quantizer: nearest palette color search with per-component
// majority voting. Top level; uses pvq_pkg, pvq_if, pvq_palette_mem,
// pvq_vote_mem and pvq_dist.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------
//   req      | in  | valid/ready        | req_type, palette_index,
//            |     |                    | component_index, light, green_red,
//            |     |                    | blue_yellow
//   rsp      | out | valid/ready        | color_index, vote_count, acknowledge
//   cfg      | in  | cfg_wen (no ready) | cfg_wdata -> num_colors
//
// Steps per transaction: a palette write goes straight to the response; a
// pixel does palette reads, two distance stages and a compare for each of
// the active colors, then a vote read and write back; a query does one vote
// read per active color; a clear rewrites every vote entry.
// Pixel and query time is set by the single read port of each memory.
// Reset starts a clearing pass over all MAX_COMPONENTS*MAX_COLORS entries (8192 by
// default) of the vote memory; req.ready stays low until it ends.
// One transaction is in flight at a time; the output register lets the next
// request be taken while a response is still stalled on rsp.ready.
module palette_vote_quantizer #(
  parameter int MAX_COLORS     = 32,
  parameter int MAX_COMPONENTS = 256,
  parameter int VOTE_WIDTH     = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  pvq_req_if.sink                    req,
  pvq_rsp_if.source                  rsp,
  input  logic                       cfg_wen,
  input  logic [pvq_pkg::CFG_W-1:0]  cfg_wdata
);
  import pvq_pkg::*;

  localparam int KW    = $clog2(MAX_COLORS);         // color index
  localparam int NW    = $clog2(MAX_COLORS + 1);     // color count
  localparam int CW    = (NW > CFG_W) ? NW : CFG_W;
  localparam int DEPTH = MAX_COMPONENTS * MAX_COLORS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + 9;                     // base product width
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_VOTE_RD = 3'd3;
  localparam logic [2:0] S_VOTE_WR = 3'd4;
  localparam logic [2:0] S_QUERY   = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]            state;
  logic [CFG_W-1:0]      num_colors;
  logic [CW-1:0]         cfg_ext;
  logic [NW-1:0]         n_active;

  // current transaction
  pal_entry_t            it_pixel;
  logic                  it_comp_ok;
  logic [AW-1:0]         base;
  logic                  comp_ok;
  logic                  pidx_ok;

  // scan control
  logic [NW-1:0]         scan_cnt;
  logic [NW-1:0]         res_cnt;
  logic                  issuing;
  logic                  p1_valid;
  logic                  q1_valid;
  logic [KW-1:0]         q1_idx;

  // search / vote results
  logic                  have;
  logic [KW-1:0]         best_idx;
  logic [DIST_W-1:0]     best_dist;
  logic [KW-1:0]         win_idx;
  logic [VOTE_WIDTH-1:0] top_votes;
  logic [VOTE_WIDTH-1:0] vote_inc;

  // clearing pass
  logic [AW-1:0]         clr_addr;
  logic                  clr_ack;

  // pending response
  logic [KW-1:0]         res_color;
  logic [VOTE_WIDTH-1:0] res_votes;
  logic                  res_ack;

  // output register
  logic                  out_valid;
  logic [COLOR_W-1:0]    out_color;
  logic [VOTE_OUT_W-1:0] out_votes;
  logic                  out_ack;
  logic                  out_free;

  // memory ports
  logic                  pal_wen;
  pal_entry_t            pal_wdata;
  pal_entry_t            pal_rdata;
  logic                  vote_wen;
  logic [AW-1:0]         vote_waddr;
  logic [VOTE_WIDTH-1:0] vote_wdata;
  logic [AW-1:0]         vote_raddr;
  logic [AW-1:0]         vote_addr;
  logic [VOTE_WIDTH-1:0] vote_rdata;
  dist_t                 dist_out;

  // num_colors above the palette size saturates
  always_comb begin
    cfg_ext  = CW'(num_colors);
    n_active = (cfg_ext > CW'(MAX_COLORS)) ? NW'(MAX_COLORS) : NW'(cfg_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_colors <= NUM_COLORS_RESET;
    end else if (cfg_wen) begin
      num_colors <= cfg_wdata;
    end
  end

  assign comp_ok = ({24'd0, req.component_index} < 32'(MAX_COMPONENTS));
  assign pidx_ok = ({27'd0, req.palette_index} < 32'(MAX_COLORS));
  assign issuing = (scan_cnt < n_active);

  assign pal_wen   = (state == S_IDLE) && req.valid && (req.req_type == REQ_WRITE) && pidx_ok;
  assign pal_wdata = '{light: req.light, green_red: req.green_red,
                       blue_yellow: req.blue_yellow};

  pvq_palette_mem #(
    .DEPTH (MAX_COLORS),
    .AW    (KW)
  ) u_palette_mem (
    .clk   (clk),
    .wen   (pal_wen),
    .waddr (KW'(req.palette_index)),
    .wdata (pal_wdata),
    .raddr (scan_cnt[KW-1:0]),
    .rdata (pal_rdata)
  );

  pvq_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p1_valid),
    .pal      (pal_rdata),
    .pix      (it_pixel),
    .out      (dist_out)
  );

  // vote address: base row of the component plus color offset
  always_comb begin
    vote_addr  = base + AW'(best_idx);
    vote_raddr = (state == S_QUERY) ? (base + AW'(scan_cnt)) : vote_addr;
    vote_wen   = (state == S_CLEAR) || (state == S_VOTE_WR);
    vote_waddr = (state == S_CLEAR) ? clr_addr : vote_addr;
    vote_inc   = (vote_rdata == '1) ? vote_rdata : (vote_rdata + 1'b1);
    vote_wdata = (state == S_CLEAR) ? '0 : vote_inc;
  end

  pvq_vote_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .VW    (VOTE_WIDTH)
  ) u_vote_mem (
    .clk   (clk),
    .wen   (vote_wen),
    .waddr (vote_waddr),
    .wdata (vote_wdata),
    .raddr (vote_raddr),
    .rdata (vote_rdata)
  );

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      clr_ack  <= 1'b0;
      p1_valid <= 1'b0;
      q1_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            if (clr_ack) begin
              res_color <= '0;
              res_votes <= '0;
              res_ack   <= 1'b1;
              state     <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            it_pixel   <= pal_wdata;
            it_comp_ok <= comp_ok;
            base       <= AW'(PW'(req.component_index) * PW'(MAX_COLORS));
            scan_cnt   <= '0;
            res_cnt    <= '0;
            have       <= 1'b0;
            best_idx   <= '0;
            win_idx    <= '0;
            top_votes  <= '0;
            p1_valid   <= 1'b0;
            q1_valid   <= 1'b0;
            case (req.req_type)
              REQ_WRITE: begin
                res_color <= '0;
                res_votes <= '0;
                res_ack   <= 1'b1;
                state     <= S_DONE;
              end
              REQ_PIXEL: begin
                state <= S_SCAN;
              end
              REQ_QUERY: begin
                if (comp_ok) begin
                  state <= S_QUERY;
                end else begin
                  res_color <= '0;
                  res_votes <= '0;
                  res_ack   <= 1'b0;
                  state     <= S_DONE;
                end
              end
              REQ_CLEAR: begin
                clr_addr <= '0;
                clr_ack  <= 1'b1;
                state    <= S_CLEAR;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // one palette read per cycle; results return in order
          p1_valid <= issuing;
          if (issuing) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          if (dist_out.valid) begin
            res_cnt <= res_cnt + 1'b1;
            if (!have || (dist_out.sq_sum < best_dist)) begin
              have      <= 1'b1;
              best_dist <= dist_out.sq_sum;
              best_idx  <= res_cnt[KW-1:0];
            end
          end
          if (res_cnt == n_active) begin
            if (it_comp_ok) begin
              state <= S_VOTE_RD;
            end else begin
              res_color <= best_idx;
              res_votes <= '0;
              res_ack   <= 1'b0;
              state     <= S_DONE;
            end
          end
        end
        S_VOTE_RD: begin
          state <= S_VOTE_WR;
        end
        S_VOTE_WR: begin
          // counter written back this cycle, saturating
          res_color <= best_idx;
          res_votes <= vote_inc;
          res_ack   <= 1'b0;
          state     <= S_DONE;
        end
        S_QUERY: begin
          q1_valid <= issuing;
          q1_idx   <= scan_cnt[KW-1:0];
          if (issuing) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          // first strict maximum wins
          if (q1_valid && (vote_rdata > top_votes)) begin
            top_votes <= vote_rdata;
            win_idx   <= q1_idx;
          end
          if (!issuing && !q1_valid) begin
            res_color <= win_idx;
            res_votes <= top_votes;
            res_ack   <= 1'b0;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if ((state == S_DONE) && out_free) begin
      out_color <= COLOR_W'(res_color);
      out_votes <= VOTE_OUT_W'(res_votes);
      out_ack   <= res_ack;
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.color_index = out_color;
  assign rsp.vote_count  = out_votes;
  assign rsp.acknowledge = out_ack;

endmodule

// ===== rtl/core/pvq_checker.sv =====
// pvq_checker: port-level assertions for palette_vote_quantizer, bound to
// the top level. Depends on pvq_pkg for request codes and widths.
module pvq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic [pvq_pkg::REQ_W-1:0]      req_type,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [pvq_pkg::COLOR_W-1:0]    rsp_color,
  input logic [pvq_pkg::VOTE_OUT_W-1:0] rsp_votes,
  input logic                           rsp_ack
);
  import pvq_pkg::*;

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_color)
      && $stable(rsp_votes) && $stable(rsp_ack))
    else $error("stalled response changed");

  // the clearing pass keeps requests out right after reset
  a_reset_busy: assert property (@(posedge clk)
    $past(rst) |-> !req_ready)
    else $error("request ready during clearing pass");

  // one transaction at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // acknowledged responses carry no color and no votes
  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ack |-> (rsp_color == '0) && (rsp_votes == '0))
    else $error("acknowledge with payload");

  // a palette write is answered through S_DONE and the output register when the output is free
  a_write_ack: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_type == REQ_WRITE) && (!rsp_valid || rsp_ready)
      |-> ##2 (rsp_valid && rsp_ack))
    else $error("palette write not acknowledged");

endmodule

bind palette_vote_quantizer pvq_checker u_pvq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.req_type),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_color (rsp.color_index),
  .rsp_votes (rsp.vote_count),
  .rsp_ack   (rsp.acknowledge)
);
